// File: src/stag_pkg.sv
// Shared constants, command struct and operation codes for the sequence tag allocator.
// No dependencies.
package stag_pkg;

  localparam int TAG_COUNT     = 256;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int TAG_W         = $clog2(TAG_COUNT);

  localparam int TAG_FIELD_W = 8;
  localparam int PAY_FIELD_W = 32;

  // free-map search: groups of 16 tags, lowest nonempty group first
  localparam int GROUP_SIZE = 16;
  localparam int OFF_W      = 4;
  localparam int GROUP_CNT  = (TAG_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GIDX_W     = (GROUP_CNT > 1) ? $clog2(GROUP_CNT) : 1;
  localparam int PAD_W      = GROUP_CNT * GROUP_SIZE;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic load;    // item accepted: capture it, start the search or table read
    logic commit;  // finish the item: update state, load the result register
  } stag_cmd_t;

endpackage

// File: src/sequence_tag_allocator.sv
// Top level of the sequence tag allocator: controller plus datapath.
// Depends on stag_pkg, stag_ctrl, stag_dp (and stag_ram through stag_dp).
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | in_operation, in_tag_in, in_payload_in
//  out     | out_valid / out_ready| out_tag_out, out_found, out_payload_out,
//          |                      | out_evicted
//
// Every item passes through accept (group search of the free map, or payload
// table read), then commit (in-group search, table write, free map update).
// in_ready is high in the idle state; a new item is taken while a result waits.
// A result still held at commit time stalls the block in the commit state.
// Synchronous active-low reset frees every tag and clears the last tag; no
// clearing pass over the payload table.
module sequence_tag_allocator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_operation,
  input  logic [stag_pkg::TAG_FIELD_W-1:0] in_tag_in,
  input  logic [stag_pkg::PAY_FIELD_W-1:0] in_payload_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [stag_pkg::TAG_FIELD_W-1:0] out_tag_out,
  output logic                             out_found,
  output logic [stag_pkg::PAY_FIELD_W-1:0] out_payload_out,
  output logic                             out_evicted
);
  import stag_pkg::*;

  stag_cmd_t cmd;

  stag_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  stag_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_operation    (in_operation),
    .in_tag_in       (in_tag_in),
    .in_payload_in   (in_payload_in),
    .out_tag_out     (out_tag_out),
    .out_found       (out_found),
    .out_payload_out (out_payload_out),
    .out_evicted     (out_evicted)
  );

endmodule

// File: src/stag_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stag_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/stag_ctrl.sv
// Controller: two-state sequencer and result valid register.
// Depends on stag_pkg.
module stag_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output stag_pkg::stag_cmd_t cmd
);
  import stag_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE);
  assign cmd.load   = (state_r == S_IDLE) && in_valid;
  assign cmd.commit = (state_r == S_EXEC) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: src/stag_dp.sv
// Datapath: free map, two-step lowest-free search, last tag, payload table, result register.
// Depends on stag_pkg and stag_ram.
module stag_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  stag_pkg::stag_cmd_t                 cmd,
  input  logic                                in_operation,
  input  logic [stag_pkg::TAG_FIELD_W-1:0]    in_tag_in,
  input  logic [stag_pkg::PAY_FIELD_W-1:0]    in_payload_in,
  output logic [stag_pkg::TAG_FIELD_W-1:0]    out_tag_out,
  output logic                                out_found,
  output logic [stag_pkg::PAY_FIELD_W-1:0]    out_payload_out,
  output logic                                out_evicted
);
  import stag_pkg::*;

  logic [TAG_COUNT-1:0]     free_map_r, free_map_nxt;
  logic [TAG_W-1:0]         last_tag_r, last_tag_nxt;
  logic                     op_r;
  logic [TAG_FIELD_W-1:0]   tag_in_r;
  logic [PAYLOAD_WIDTH-1:0] payload_r;
  logic [GIDX_W-1:0]        grp_r, grp_nxt;
  logic                     any_free_r, any_free_nxt;

  logic [TAG_FIELD_W-1:0]   res_tag_r;
  logic                     res_found_r;
  logic [PAY_FIELD_W-1:0]   res_payload_r;
  logic                     res_evicted_r;

  logic [PAD_W-1:0]         free_pad;
  logic [GROUP_CNT-1:0]     grp_nz;
  logic [GROUP_SIZE-1:0]    grp_bits;
  logic [OFF_W-1:0]         off;
  logic [TAG_W-1:0]         free_tag;
  logic [TAG_W-1:0]         wrap_tag;
  logic [TAG_W-1:0]         new_tag;
  logic [TAG_W-1:0]         rel_idx;
  logic                     is_alloc;
  logic                     hit;
  logic [PAYLOAD_WIDTH-1:0] rd_data;

  // padding bits past the table never count as free
  assign free_pad = PAD_W'(free_map_r);

  always_comb begin
    int g;
    any_free_nxt = 1'b0;
    grp_nxt      = '0;
    for (g = 0; g < GROUP_CNT; g++) begin
      grp_nz[g] = |free_pad[g*GROUP_SIZE +: GROUP_SIZE];
    end
    for (g = GROUP_CNT - 1; g >= 0; g--) begin
      if (grp_nz[g]) begin
        grp_nxt      = GIDX_W'(g);
        any_free_nxt = 1'b1;
      end
    end
  end

  assign grp_bits = free_pad[grp_r*GROUP_SIZE +: GROUP_SIZE];

  always_comb begin
    int b;
    off = '0;
    for (b = GROUP_SIZE - 1; b >= 0; b--) begin
      if (grp_bits[b]) off = OFF_W'(b);
    end
  end

  assign free_tag = TAG_W'({grp_r, off});
  assign wrap_tag = (32'(last_tag_r) == TAG_COUNT - 1) ? '0 : last_tag_r + 1'b1;
  assign new_tag  = any_free_r ? free_tag : wrap_tag;
  assign is_alloc = (op_r == OP_ALLOC);
  assign rel_idx  = TAG_W'(tag_in_r);
  assign hit      = (32'(tag_in_r) < TAG_COUNT) && !free_map_r[rel_idx];

  stag_ram #(
    .WIDTH (PAYLOAD_WIDTH),
    .DEPTH (TAG_COUNT)
  ) u_payload_ram (
    .clk   (clk),
    .we    (cmd.commit && is_alloc),
    .waddr (new_tag),
    .wdata (payload_r),
    .re    (cmd.load),
    .raddr (TAG_W'(in_tag_in)),
    .rdata (rd_data)
  );

  always_comb begin
    free_map_nxt = free_map_r;
    last_tag_nxt = last_tag_r;
    if (cmd.commit) begin
      if (is_alloc) begin
        last_tag_nxt = new_tag;
        if (any_free_r) free_map_nxt[new_tag] = 1'b0;
      end else if (hit) begin
        free_map_nxt[rel_idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_map_r <= '1;
      last_tag_r <= '0;
    end else begin
      free_map_r <= free_map_nxt;
      last_tag_r <= last_tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_operation;
      tag_in_r   <= in_tag_in;
      payload_r  <= PAYLOAD_WIDTH'(in_payload_in);
      grp_r      <= grp_nxt;
      any_free_r <= any_free_nxt;
    end
    if (cmd.commit) begin
      res_tag_r     <= is_alloc ? TAG_FIELD_W'(new_tag) : tag_in_r;
      res_found_r   <= is_alloc || hit;
      res_payload_r <= (!is_alloc && hit) ? PAY_FIELD_W'(rd_data) : '0;
      res_evicted_r <= is_alloc && !any_free_r;
    end
  end

  assign out_tag_out     = res_tag_r;
  assign out_found       = res_found_r;
  assign out_payload_out = res_payload_r;
  assign out_evicted     = res_evicted_r;

`ifndef SYNTHESIS
  a_alloc_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && is_alloc) |=> !free_map_r[$past(new_tag)])
    else $error("allocated tag still free");

  a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && is_alloc && !any_free_r) |-> (free_map_r == '0))
    else $error("eviction while a tag is free");

  a_release_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && !is_alloc && hit) |=> free_map_r[$past(rel_idx)])
    else $error("released tag not freed");

  a_miss_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && !is_alloc && !hit) |=> $stable(free_map_r) && $stable(last_tag_r))
    else $error("release miss changed state");
`endif

endmodule
